// ----- hdl/fat_cau_pkg.sv -----
// ----------------------------------------------------------------------------
// fat_cau_pkg
// Shared types, constants and helpers of the FAT cluster address unit.
// ----------------------------------------------------------------------------
package fat_cau_pkg;

    // Field widths
    localparam int unsigned CLUSTER_W  = 28;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned LBA_W      = 32;
    localparam int unsigned OFFSET_W   = 9;
    localparam int unsigned ROOTLEN_W  = 13;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Sector geometry: 512-byte sectors, 16 root entries per sector
    localparam int unsigned SECTOR_SHIFT    = 9;
    localparam int unsigned ROOT_ENT_SHIFT  = 4;

    // Cluster count limits that select the FAT type
    localparam logic [19:0] FAT12_LIMIT = 20'd4085;
    localparam logic [23:0] FAT16_LIMIT = 24'd65525;

    // End-of-chain markers
    localparam logic [CLUSTER_W-1:0] FAT12_END = 28'h0000FF8;
    localparam logic [CLUSTER_W-1:0] FAT16_END = 28'h000FFF8;
    localparam logic [CLUSTER_W-1:0] FAT32_END = 28'hFFFFFF8;

    typedef enum logic [1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2
    } kind_t;

    typedef enum logic {
        MODE_LOCATE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARTITION_START  = 3'd0,
        CFG_RESERVED_COUNT   = 3'd1,
        CFG_TABLE_COPIES     = 3'd2,
        CFG_TABLE_LENGTH     = 3'd3,
        CFG_ROOT_ENTRY_COUNT = 3'd4,
        CFG_VOLUME_SECTORS   = 3'd5,
        CFG_CLUSTER_SECTORS  = 3'd6
    } cfg_idx_t;

    // Boot-sector geometry as held by the register file
    typedef struct packed {
        logic [31:0] partition_start;
        logic [15:0] reserved_count;
        logic [7:0]  table_copies;
        logic [31:0] table_length;
        logic [15:0] root_entry_count;
        logic [31:0] volume_sectors;
        logic [7:0]  cluster_sectors;
    } cfg_t;

    // End-of-chain marker for a FAT type
    function automatic logic [CLUSTER_W-1:0] end_mark(input kind_t kind);
        logic [CLUSTER_W-1:0] mark;
        case (kind)
            KIND_FAT12: mark = FAT12_END;
            KIND_FAT16: mark = FAT16_END;
            default:    mark = FAT32_END;
        endcase
        return mark;
    endfunction

endpackage

// ----- hdl/fat_cau_if.sv -----
// ----------------------------------------------------------------------------
// fat_cau_if
// Request and response channels of the FAT cluster address unit.
// ----------------------------------------------------------------------------

// Request channel: one lookup or decode per beat
interface fat_cau_req_if import fat_cau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [CLUSTER_W-1:0] cluster;
    logic [WORD_W-1:0]    entry_word;

    modport source (output valid, mode, cluster, entry_word, input ready);
    modport sink   (input valid, mode, cluster, entry_word, output ready);
endinterface

// Response channel: one result per request beat
interface fat_cau_rsp_if import fat_cau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LBA_W-1:0]     data_sector;
    logic [LBA_W-1:0]     table_sector;
    logic [OFFSET_W-1:0]  entry_byte;
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 chain_end;
    logic [1:0]           table_kind;
    logic [LBA_W-1:0]     root_start;
    logic [ROOTLEN_W-1:0] root_length;
    logic                 status;

    modport source (output valid, data_sector, table_sector, entry_byte, next_cluster,
                    chain_end, table_kind, root_start, root_length, status,
                    input ready);
    modport sink   (input valid, data_sector, table_sector, entry_byte, next_cluster,
                    chain_end, table_kind, root_start, root_length, status,
                    output ready);
endinterface

// ----- hdl/fat_cau_regs.sv -----
// ----------------------------------------------------------------------------
// fat_cau_regs
// Geometry register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module fat_cau_regs import fat_cau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an unknown index leaves everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PARTITION_START:  cfg_next.partition_start  = cfg_data;
                CFG_RESERVED_COUNT:   cfg_next.reserved_count   = cfg_data[15:0];
                CFG_TABLE_COPIES:     cfg_next.table_copies     = cfg_data[7:0];
                CFG_TABLE_LENGTH:     cfg_next.table_length     = cfg_data;
                CFG_ROOT_ENTRY_COUNT: cfg_next.root_entry_count = cfg_data[15:0];
                CFG_VOLUME_SECTORS:   cfg_next.volume_sectors   = cfg_data;
                CFG_CLUSTER_SECTORS:  cfg_next.cluster_sectors  = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.partition_start  <= 32'd0;
            cfg_reg.reserved_count   <= 16'd1;
            cfg_reg.table_copies     <= 8'd2;
            cfg_reg.table_length     <= 32'd0;
            cfg_reg.root_entry_count <= 16'd0;
            cfg_reg.volume_sectors   <= 32'd0;
            cfg_reg.cluster_sectors  <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/fat_cau_pipe.sv -----
// ----------------------------------------------------------------------------
// fat_cau_pipe
// Four-stage address pipeline: products, sums and checks, FAT type, results.
// ----------------------------------------------------------------------------
module fat_cau_pipe import fat_cau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    fat_cau_req_if.sink  req,
    fat_cau_rsp_if.source rsp
);

    // Per-stage ready: a stage takes a beat when empty or when it moves on
    logic rdy1, rdy2, rdy3, rdy4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign rdy4      = !v4_reg || rsp.ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;

    // ------------------------------------------------------------------
    // Stage 1: table product, root length, type thresholds, FAT start
    // ------------------------------------------------------------------
    mode_t                s1_mode_reg;
    logic [CLUSTER_W-1:0] s1_cluster_reg;
    logic [WORD_W-1:0]    s1_word_reg;
    logic [39:0]          s1_tables_reg;
    logic [ROOTLEN_W-1:0] s1_root_len_reg;
    logic [LBA_W-1:0]     s1_fat_start_reg;
    logic [CLUSTER_W:0]   s1_off12_reg;
    logic [19:0]          s1_thr12_reg;
    logic [23:0]          s1_thr16_reg;

    logic [39:0]          s1_tables_next;
    logic [ROOTLEN_W-1:0] s1_root_len_next;
    logic [16:0]          root_round;

    always_comb
    begin
        s1_tables_next   = {8'd0, cfg.table_length} * {32'd0, cfg.table_copies};
        root_round       = {1'b0, cfg.root_entry_count} + 17'd15;
        s1_root_len_next = root_round[ROOT_ENT_SHIFT +: ROOTLEN_W];
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_mode_reg      <= mode_t'(req.mode);
            s1_cluster_reg   <= req.cluster;
            s1_word_reg      <= req.entry_word;
            s1_tables_reg    <= s1_tables_next;
            s1_root_len_reg  <= s1_root_len_next;
            s1_fat_start_reg <= cfg.partition_start + {16'd0, cfg.reserved_count};
            s1_off12_reg     <= {1'b0, req.cluster} + {2'b00, req.cluster[CLUSTER_W-1:1]};
            s1_thr12_reg     <= FAT12_LIMIT * {12'd0, cfg.cluster_sectors};
            s1_thr16_reg     <= FAT16_LIMIT * {16'd0, cfg.cluster_sectors};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: overhead and geometry check, root start, cluster product
    // ------------------------------------------------------------------
    mode_t                s2_mode_reg;
    logic [CLUSTER_W-1:0] s2_cluster_reg;
    logic [WORD_W-1:0]    s2_word_reg;
    logic [ROOTLEN_W-1:0] s2_root_len_reg;
    logic [LBA_W-1:0]     s2_fat_start_reg;
    logic [CLUSTER_W:0]   s2_off12_reg;
    logic [19:0]          s2_thr12_reg;
    logic [23:0]          s2_thr16_reg;
    logic [LBA_W-1:0]     s2_overhead_reg;
    logic                 s2_err_reg;
    logic [LBA_W-1:0]     s2_root_start_reg;
    logic [LBA_W-1:0]     s2_prod_reg;

    logic [40:0]          overhead;

    assign overhead = {25'd0, cfg.reserved_count} + {1'b0, s1_tables_reg}
                    + {28'd0, s1_root_len_reg};

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_mode_reg       <= s1_mode_reg;
            s2_cluster_reg    <= s1_cluster_reg;
            s2_word_reg       <= s1_word_reg;
            s2_root_len_reg   <= s1_root_len_reg;
            s2_fat_start_reg  <= s1_fat_start_reg;
            s2_off12_reg      <= s1_off12_reg;
            s2_thr12_reg      <= s1_thr12_reg;
            s2_thr16_reg      <= s1_thr16_reg;
            s2_overhead_reg   <= overhead[LBA_W-1:0];
            s2_err_reg        <= (cfg.cluster_sectors == 8'd0)
                                 || (overhead > {9'd0, cfg.volume_sectors});
            s2_root_start_reg <= s1_fat_start_reg + s1_tables_reg[LBA_W-1:0];
            s2_prod_reg       <= ({4'd0, s1_cluster_reg} - 32'd2)
                                 * {24'd0, cfg.cluster_sectors};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: FAT type from cluster count, data start
    // ------------------------------------------------------------------
    mode_t                s3_mode_reg;
    logic [CLUSTER_W-1:0] s3_cluster_reg;
    logic [WORD_W-1:0]    s3_word_reg;
    logic [ROOTLEN_W-1:0] s3_root_len_reg;
    logic [LBA_W-1:0]     s3_fat_start_reg;
    logic [CLUSTER_W:0]   s3_off12_reg;
    logic                 s3_err_reg;
    logic [LBA_W-1:0]     s3_root_start_reg;
    logic [LBA_W-1:0]     s3_prod_reg;
    logic [LBA_W-1:0]     s3_data_start_reg;
    kind_t                s3_kind_reg;

    logic [LBA_W-1:0]     data_area;
    kind_t                kind_next;

    // floor(area / spc) < limit  is the same as  area < limit * spc
    always_comb
    begin
        data_area = cfg.volume_sectors - s2_overhead_reg;
        if (data_area < {12'd0, s2_thr12_reg})
            kind_next = KIND_FAT12;
        else if (data_area < {8'd0, s2_thr16_reg})
            kind_next = KIND_FAT16;
        else
            kind_next = KIND_FAT32;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_mode_reg       <= s2_mode_reg;
            s3_cluster_reg    <= s2_cluster_reg;
            s3_word_reg       <= s2_word_reg;
            s3_root_len_reg   <= s2_root_len_reg;
            s3_fat_start_reg  <= s2_fat_start_reg;
            s3_off12_reg      <= s2_off12_reg;
            s3_err_reg        <= s2_err_reg;
            s3_root_start_reg <= s2_root_start_reg;
            s3_prod_reg       <= s2_prod_reg;
            s3_data_start_reg <= s2_root_start_reg + {19'd0, s2_root_len_reg};
            s3_kind_reg       <= kind_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: entry offset, table sector, next cluster, output register
    // ------------------------------------------------------------------
    logic [29:0]          offset;
    logic [CLUSTER_W-1:0] next_val;
    logic [CLUSTER_W-1:0] mark;
    logic [LBA_W-1:0]     o_data_next;
    logic [LBA_W-1:0]     o_table_next;
    logic [OFFSET_W-1:0]  o_offset_next;
    logic [CLUSTER_W-1:0] o_next_next;
    logic                 o_end_next;
    logic [1:0]           o_kind_next;
    logic [LBA_W-1:0]     o_root_next;
    logic [ROOTLEN_W-1:0] o_rlen_next;
    logic                 o_status_next;

    logic [LBA_W-1:0]     o_data_reg;
    logic [LBA_W-1:0]     o_table_reg;
    logic [OFFSET_W-1:0]  o_offset_reg;
    logic [CLUSTER_W-1:0] o_next_reg;
    logic                 o_end_reg;
    logic [1:0]           o_kind_reg;
    logic [LBA_W-1:0]     o_root_reg;
    logic [ROOTLEN_W-1:0] o_rlen_reg;
    logic                 o_status_reg;

    always_comb
    begin
        mark = end_mark(s3_kind_reg);

        // Entry byte offset: 1.5, 2 or 4 bytes per entry
        case (s3_kind_reg)
            KIND_FAT12: offset = {1'b0, s3_off12_reg};
            KIND_FAT16: offset = {1'b0, s3_cluster_reg, 1'b0};
            default:    offset = {s3_cluster_reg, 2'b00};
        endcase

        // Mask the fetched word; odd FAT12 entries sit one nibble up
        case (s3_kind_reg)
            KIND_FAT12: next_val = s3_cluster_reg[0] ? {16'd0, s3_word_reg[15:4]}
                                                     : {16'd0, s3_word_reg[11:0]};
            KIND_FAT16: next_val = {12'd0, s3_word_reg[15:0]};
            default:    next_val = s3_word_reg[CLUSTER_W-1:0];
        endcase

        o_table_next  = s3_fat_start_reg + {11'd0, offset[29:SECTOR_SHIFT]};
        o_offset_next = offset[OFFSET_W-1:0];
        o_kind_next   = s3_kind_reg;
        o_root_next   = s3_root_start_reg;
        o_rlen_next   = s3_root_len_reg;
        o_status_next = 1'b0;

        if (s3_mode_reg == MODE_LOCATE)
        begin
            o_data_next = s3_prod_reg + s3_data_start_reg;
            o_next_next = '0;
            o_end_next  = (s3_cluster_reg >= mark);
        end
        else
        begin
            o_data_next = '0;
            o_next_next = next_val;
            o_end_next  = (next_val >= mark);
        end

        // Bad geometry: flag it and drop every other field
        if (s3_err_reg)
        begin
            o_data_next   = '0;
            o_table_next  = '0;
            o_offset_next = '0;
            o_next_next   = '0;
            o_end_next    = 1'b0;
            o_kind_next   = '0;
            o_root_next   = '0;
            o_rlen_next   = '0;
            o_status_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            o_data_reg   <= o_data_next;
            o_table_reg  <= o_table_next;
            o_offset_reg <= o_offset_next;
            o_next_reg   <= o_next_next;
            o_end_reg    <= o_end_next;
            o_kind_reg   <= o_kind_next;
            o_root_reg   <= o_root_next;
            o_rlen_reg   <= o_rlen_next;
            o_status_reg <= o_status_next;
        end
    end

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // Drive the response channel
    assign rsp.valid        = v4_reg;
    assign rsp.data_sector  = o_data_reg;
    assign rsp.table_sector = o_table_reg;
    assign rsp.entry_byte   = o_offset_reg;
    assign rsp.next_cluster = o_next_reg;
    assign rsp.chain_end    = o_end_reg;
    assign rsp.table_kind   = o_kind_reg;
    assign rsp.root_start   = o_root_reg;
    assign rsp.root_length  = o_rlen_reg;
    assign rsp.status       = o_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> v1_reg)
        else $error("accepted request beat did not enter stage 1");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(s3_data_start_reg) && $stable(s3_kind_reg)))
        else $error("stage 3 lost or changed its beat under stall");

    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status) |-> (rsp.data_sector == '0 && rsp.table_sector == '0
            && rsp.next_cluster == '0 && rsp.root_start == '0 && !rsp.chain_end))
        else $error("geometry error result carries nonzero fields");

    a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.next_cluster != '0) |-> (rsp.data_sector == '0))
        else $error("decode result carries a data sector");

endmodule

// ----- hdl/fat_cluster_address_unit.sv -----
// ----------------------------------------------------------------------------
// fat_cluster_address_unit
// FAT12/16/32 cluster address and chain decode unit.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        mode, cluster, entry_word
//   rsp      out  valid/ready        data_sector .. status (one beat per req)
//   cfg      in   cfg_we             cfg_index, cfg_data (no read-back)
//
// Takes one request beat per cycle while the response is not stalled; each
// result passes through the four register stages (table product, overhead
// check, FAT type compare, result select) after acceptance.
// Reset loads the default geometry and empties the pipeline.
// A stalled response backs up stage by stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module fat_cluster_address_unit import fat_cau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fat_cau_req_if.sink           req,
    fat_cau_rsp_if.source         rsp
);

    cfg_t cfg;

    // Geometry registers
    fat_cau_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Address pipeline
    fat_cau_pipe u_pipe
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
